/* design/rsi_pkg.sv */
// ============================================================================
// rsi_pkg
// Shared constants and types for the relative strength index block.
// ============================================================================
package rsi_pkg;

    // Default sizes for the top-level parameters
    localparam int MAX_PERIOD_DEF = 64;
    localparam int PRICE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration registers
    localparam int PERIOD_BITS    = 7;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 7;
    localparam int PERIOD_RESET   = 14;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE   = 1'b1;

    // Averaging modes
    localparam logic MODE_SMOOTHED = 1'b0;
    localparam logic MODE_STANDARD = 1'b1;

    // Result fields
    localparam int RSI_BITS    = 23;
    localparam int STATUS_BITS = 2;
    localparam int MDATA_BITS  = 24;

    typedef logic [STATUS_BITS-1:0] status_t;

    localparam status_t STAT_WARMUP = 2'd0;
    localparam status_t STAT_VALID  = 2'd1;
    localparam status_t STAT_UNDEF  = 2'd2;

    // Full-scale RSI integer part and its width
    localparam int                    SCALE_BITS = 7;
    localparam logic [SCALE_BITS-1:0] RSI_SCALE  = 7'd100;

endpackage

/* design/rsi_ram.sv */
// ============================================================================
// rsi_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module rsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/rsi_div.sv */
// ============================================================================
// rsi_div
// Restoring divider, one quotient bit per cycle. The caller preloads the
// partial remainder (must be below the divisor) and the dividend bits still
// to shift in, MSB aligned, plus the number of steps to run.
// ============================================================================
module rsi_div #(
    parameter int DW = 49,
    parameter int QW = 48
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DW-1:0]            rem_init,
    input  logic [QW-1:0]            dividend,
    input  logic [$clog2(QW+1)-1:0]  count,
    input  logic [DW-1:0]            divisor,
    output logic                     done,
    output logic [QW-1:0]            quot
);

    localparam int CW = $clog2(QW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] bits_reg;
    logic [DW-1:0] div_reg;
    logic [QW-1:0] q_reg;

    logic [DW:0]   trial;
    logic [DW:0]   trial_sub;
    logic          trial_ge;

    // One restoring step: bring down the next bit, subtract if it fits
    assign trial     = {rem_reg, bits_reg[QW-1]};
    assign trial_ge  = trial >= {1'b0, div_reg};
    assign trial_sub = trial - {1'b0, div_reg};

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= count;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            bits_reg <= dividend;
            div_reg  <= divisor;
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
            bits_reg <= {bits_reg[QW-2:0], 1'b0};
            q_reg    <= {q_reg[QW-2:0], trial_ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* design/relative_strength_index.sv */
// ============================================================================
// relative_strength_index
// Wilder relative strength index over a stream of prices, smoothed or
// simple-window averaging, one result transaction per price transaction.
// ============================================================================
//
//  channel  | direction | signals                          | contents
//  ---------+-----------+----------------------------------+--------------------
//  s_*      | in        | s_tvalid s_tready s_tdata s_tuser| price, series_start
//  m_*      | out       | m_tvalid m_tready m_tdata m_tuser| rsi_value, status
//  cfg_*    | in        | cfg_we cfg_index cfg_data        | period, mode
//
//  One price is in flight at a time; s_tready is high only when idle.
//  A series start or warm-up price goes straight to the output state. A
//  smoothed update runs on the one-bit-per-cycle divider, which is shared
//  by both average updates and the ratio. Window averaging first reads back
//  and sums the stored moves of the period. The result waits in its register
//  until m_tready; rst_n clears the control and series state only.
// ============================================================================
module relative_strength_index #(
    parameter int MAX_PERIOD = rsi_pkg::MAX_PERIOD_DEF,
    parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF,
    parameter int FRAC_BITS  = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((PRICE_BITS+7)/8)*8-1:0]        s_tdata,   // price
    input  logic                                   s_tuser,   // series_start
    // output stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [rsi_pkg::MDATA_BITS-1:0]         m_tdata,   // rsi_value
    output logic [rsi_pkg::STATUS_BITS-1:0]        m_tuser,   // status
    // configuration
    input  logic                                   cfg_we,
    input  logic [rsi_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [rsi_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int PB   = rsi_pkg::PERIOD_BITS;
    localparam int SB   = rsi_pkg::SCALE_BITS;
    localparam int AW   = PRICE_BITS + FRAC_BITS;   // averages
    localparam int NW   = AW + PB;                  // dividends and products
    localparam int DW   = AW + 1;                   // divisor / remainder
    localparam int SUMW = PRICE_BITS + PB;          // window sums
    localparam int MSW  = $clog2(MAX_PERIOD + 1);
    localparam int SLW  = $clog2(MAX_PERIOD);
    localparam int CW   = $clog2(AW + 1);
    localparam int CMPW = (MSW > PB) ? MSW : PB;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIVP = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_RMUL = 3'd5;
    localparam logic [2:0] S_RDIV = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]             state_reg, state_next;

    logic [PB-1:0]          period_reg;
    logic                   mode_reg;
    logic [PRICE_BITS-1:0]  last_price_reg;
    logic [MSW-1:0]         moves_reg;
    logic [AW-1:0]          gavg_reg;
    logic [AW-1:0]          lavg_reg;
    logic [SLW-1:0]         slot_reg;
    logic [PB-1:0]          p_reg;
    logic                   smooth_reg;
    logic                   side_reg;
    logic                   ratio_reg;
    logic                   acc_vld_reg;
    logic [PB-1:0]          issue_reg;
    logic [SLW-1:0]         rd_ptr_reg;

    logic [PRICE_BITS-1:0]  mag_reg;
    logic                   loss_reg;
    logic [NW-1:0]          prod_reg;
    logic [DW-1:0]          tot_reg;
    logic [SUMW-1:0]        gsum_reg;
    logic [SUMW-1:0]        lsum_reg;
    logic [rsi_pkg::RSI_BITS-1:0] rsi_reg;
    rsi_pkg::status_t       status_reg;

    logic                   in_acc;
    logic [PRICE_BITS-1:0]  price_in;
    logic                   rise;
    logic                   lossf;
    logic [PRICE_BITS-1:0]  diff;
    logic [MSW-1:0]         moves_next;
    logic [SLW-1:0]         slot_next;
    logic [PB-1:0]          eff_p;
    logic                   smooth_go;
    logic                   window_go;

    logic [AW-1:0]          cur_avg;
    logic [PRICE_BITS-1:0]  cur_move;
    logic [NW-1:0]          smooth_num;
    logic [NW-1:0]          win_num;
    logic [NW-1:0]          num;
    logic [AW-1:0]          mul_a;
    logic [PB-1:0]          mul_k;
    logic [NW-1:0]          mul_p;

    logic                   div_start;
    logic [DW-1:0]          div_rem;
    logic [AW-1:0]          div_bits;
    logic [CW-1:0]          div_cnt;
    logic [DW-1:0]          div_dvs;
    logic                   div_done;
    logic [AW-1:0]          div_q;

    logic                   rd_en;
    logic [PRICE_BITS:0]    rd_data;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign price_in = s_tdata[PRICE_BITS-1:0];

    assign rise  = price_in > last_price_reg;
    assign lossf = price_in < last_price_reg;
    assign diff  = rise ? (price_in - last_price_reg) : (last_price_reg - price_in);

    assign moves_next = (moves_reg < MSW'(MAX_PERIOD)) ? (moves_reg + 1'b1) : moves_reg;
    assign slot_next  = (slot_reg == SLW'(MAX_PERIOD - 1)) ? '0 : (slot_reg + 1'b1);

    // Effective period: zero acts as one, clamp to the window size
    always_comb
    begin
        if (period_reg == '0)
        begin
            eff_p = PB'(1);
        end
        else if (int'(period_reg) > MAX_PERIOD)
        begin
            eff_p = PB'(MAX_PERIOD);
        end
        else
        begin
            eff_p = period_reg;
        end
    end

    assign smooth_go = (CMPW'(moves_reg) >= CMPW'(eff_p)) && (mode_reg == rsi_pkg::MODE_SMOOTHED);
    assign window_go = CMPW'(moves_next) >= CMPW'(eff_p);

    // ------------------------------------------------------------------
    // Shared multiplier: avg*(p-1) for smoothing, gain*100 for the ratio
    // ------------------------------------------------------------------
    assign cur_avg  = side_reg ? lavg_reg : gavg_reg;
    assign cur_move = (side_reg == loss_reg) ? mag_reg : '0;
    assign mul_a    = (state_reg == S_RMUL) ? gavg_reg : cur_avg;
    assign mul_k    = (state_reg == S_RMUL) ? PB'(rsi_pkg::RSI_SCALE) : (p_reg - 1'b1);
    assign mul_p    = {{PB{1'b0}}, mul_a} * {{AW{1'b0}}, mul_k};

    // ------------------------------------------------------------------
    // Divider operand selection
    // ------------------------------------------------------------------
    assign smooth_num = prod_reg + NW'({cur_move, {FRAC_BITS{1'b0}}});
    assign win_num    = {(side_reg ? lsum_reg : gsum_reg), {FRAC_BITS{1'b0}}};
    assign num        = smooth_reg ? smooth_num : win_num;

    always_comb
    begin
        if (state_reg == S_RDIV)
        begin
            // Integer part is below 128, so the top bits start as remainder
            div_start = (tot_reg != '0);
            div_rem   = DW'(prod_reg[NW-1:SB]);
            div_bits  = {prod_reg[SB-1:0], {(AW-SB){1'b0}}};
            div_cnt   = CW'(SB + FRAC_BITS);
            div_dvs   = tot_reg;
        end
        else
        begin
            // Quotient fits the average width, so the top bits start as remainder
            div_start = (state_reg == S_DIVP);
            div_rem   = DW'(num[NW-1:AW]);
            div_bits  = num[AW-1:0];
            div_cnt   = CW'(AW);
            div_dvs   = DW'(p_reg);
        end
    end

    rsi_div #(
        .DW (DW),
        .QW (AW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem),
        .dividend (div_bits),
        .count    (div_cnt),
        .divisor  (div_dvs),
        .done     (div_done),
        .quot     (div_q)
    );

    // ------------------------------------------------------------------
    // Move window: newest move written on accept, read back newest first
    // ------------------------------------------------------------------
    assign rd_en = (state_reg == S_SUM) && (issue_reg != p_reg);

    rsi_ram #(
        .WIDTH (PRICE_BITS + 1),
        .DEPTH (MAX_PERIOD)
    ) u_window (
        .clk   (clk),
        .we    (in_acc && !s_tuser),
        .waddr (slot_reg),
        .wdata ({lossf, diff}),
        .re    (rd_en),
        .raddr (rd_ptr_reg),
        .rdata (rd_data)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser)
                    begin
                        state_next = S_OUT;
                    end
                    else if (smooth_go)
                    begin
                        state_next = S_MUL;
                    end
                    else if (window_go)
                    begin
                        state_next = S_SUM;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_MUL:  state_next = S_DIVP;
            S_DIVP: state_next = S_WAIT;
            S_SUM:
            begin
                if ((issue_reg == p_reg) && !acc_vld_reg)
                begin
                    state_next = S_DIVP;
                end
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    if (ratio_reg)
                    begin
                        state_next = S_OUT;
                    end
                    else if (!side_reg)
                    begin
                        state_next = smooth_reg ? S_MUL : S_DIVP;
                    end
                    else
                    begin
                        state_next = S_RMUL;
                    end
                end
            end
            S_RMUL: state_next = S_RDIV;
            S_RDIV: state_next = (tot_reg == '0) ? S_OUT : S_WAIT;
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and series state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            period_reg     <= PB'(rsi_pkg::PERIOD_RESET);
            mode_reg       <= rsi_pkg::MODE_SMOOTHED;
            last_price_reg <= '0;
            moves_reg      <= '0;
            gavg_reg       <= '0;
            lavg_reg       <= '0;
            slot_reg       <= '0;
            p_reg          <= PB'(1);
            smooth_reg     <= 1'b0;
            side_reg       <= 1'b0;
            ratio_reg      <= 1'b0;
            acc_vld_reg    <= 1'b0;
            issue_reg      <= '0;
            rd_ptr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            acc_vld_reg <= rd_en;

            // Configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    rsi_pkg::REG_PERIOD: period_reg <= cfg_data[PB-1:0];
                    rsi_pkg::REG_MODE:   mode_reg   <= cfg_data[0];
                    default:             mode_reg   <= mode_reg;
                endcase
            end

            // New price transaction
            if (in_acc)
            begin
                last_price_reg <= price_in;
                if (s_tuser)
                begin
                    moves_reg <= '0;
                    gavg_reg  <= '0;
                    lavg_reg  <= '0;
                    slot_reg  <= '0;
                end
                else
                begin
                    moves_reg  <= moves_next;
                    slot_reg   <= slot_next;
                    p_reg      <= eff_p;
                    smooth_reg <= smooth_go;
                    side_reg   <= 1'b0;
                    ratio_reg  <= 1'b0;
                    issue_reg  <= '0;
                    rd_ptr_reg <= slot_reg;
                end
            end

            // Window read address walks backward from the newest move
            if (rd_en)
            begin
                issue_reg  <= issue_reg + 1'b1;
                rd_ptr_reg <= (rd_ptr_reg == '0) ? SLW'(MAX_PERIOD - 1) : (rd_ptr_reg - 1'b1);
            end

            if (state_reg == S_DIVP && state_next == S_WAIT && !smooth_reg && !side_reg)
            begin
                side_reg <= 1'b0;
            end

            if (state_reg == S_RDIV)
            begin
                ratio_reg <= 1'b1;
            end

            // Average update results
            if (state_reg == S_WAIT && div_done && !ratio_reg)
            begin
                if (side_reg)
                begin
                    lavg_reg <= div_q;
                end
                else
                begin
                    gavg_reg <= div_q;
                    side_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mag_reg    <= diff;
            loss_reg   <= lossf;
            gsum_reg   <= '0;
            lsum_reg   <= '0;
            rsi_reg    <= '0;
            status_reg <= rsi_pkg::STAT_WARMUP;
        end

        if (acc_vld_reg)
        begin
            if (rd_data[PRICE_BITS])
            begin
                lsum_reg <= lsum_reg + SUMW'(rd_data[PRICE_BITS-1:0]);
            end
            else
            begin
                gsum_reg <= gsum_reg + SUMW'(rd_data[PRICE_BITS-1:0]);
            end
        end

        if (state_reg == S_MUL || state_reg == S_RMUL)
        begin
            prod_reg <= mul_p;
        end

        if (state_reg == S_RMUL)
        begin
            tot_reg <= DW'(gavg_reg) + DW'(lavg_reg);
        end

        if (state_reg == S_RDIV && tot_reg == '0)
        begin
            status_reg <= rsi_pkg::STAT_UNDEF;
        end

        if (state_reg == S_WAIT && div_done && ratio_reg)
        begin
            rsi_reg    <= rsi_pkg::RSI_BITS'(div_q);
            status_reg <= rsi_pkg::STAT_VALID;
        end
    end

    // Output stream
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = rsi_pkg::MDATA_BITS'(rsi_reg);
    assign m_tuser  = status_reg;

endmodule

/* design/rsi_checker.sv */
// ============================================================================
// rsi_port_props
// Port-level checks for the relative strength index block, bound to the top.
// ============================================================================
module rsi_port_props (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rsi_pkg::MDATA_BITS-1:0]    m_tdata,
    input logic [rsi_pkg::STATUS_BITS-1:0]   m_tuser
);

    // Only one price in flight: no input while a result is pending
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    // An accepted price keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready right after accept");

    // Only a valid status carries a nonzero RSI
    a_zero_unless_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != rsi_pkg::STAT_VALID) |-> (m_tdata == '0))
        else $error("nonzero rsi without valid status");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind relative_strength_index rsi_port_props u_rsi_port_props (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
